/* rtl/core/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

   typedef enum logic [2:0] {
      PHASE_HDR0 = 3'd0,
      PHASE_HDR1 = 3'd1,
      PHASE_EXT  = 3'd2,
      PHASE_KEY  = 3'd3,
      PHASE_BODY = 3'd4
   } phase_type;

   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] KEY_BYTES      = 4'd4;

   typedef struct packed {
      logic       emit;
      logic [7:0] data_byte;
      logic       last_in_frame;
      logic       empty_frame;
   } parse_result_type;

endpackage

/* rtl/core/wsd_req_if.sv */
// ----------------------------------------------------------------------------
// wsd_req_if
// Request channel: one received byte per request.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/wsd_rsp_if.sv */
// ----------------------------------------------------------------------------
// wsd_rsp_if
// Response channel: one unmasked payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_in_frame;
   logic       empty_frame;

   modport source (output valid, output data_byte, output last_in_frame,
                   output empty_frame, input ready);
   modport sink   (input valid, input data_byte, input last_in_frame,
                   input empty_frame, output ready);
endinterface

/* rtl/core/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header, extended length and mask key parser with payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       rx_byte,
   output parse_result_type result
);

   phase_type              phase_ff, phase_in;
   logic [3:0]             ext_left_ff, ext_left_in;
   logic [LENGTH_BITS-1:0] frame_length_ff, frame_length_in;
   logic [31:0]            mask_key_ff, mask_key_in;
   logic [LENGTH_BITS-1:0] position_ff, position_in;
   logic [LENGTH_BITS-1:0] position_next;
   logic [6:0]             code;
   logic [7:0]             key_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_HDR0;
         ext_left_ff     <= 4'd0;
         frame_length_ff <= '0;
         mask_key_ff     <= 32'd0;
         position_ff     <= '0;
      end else if (take) begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         frame_length_ff <= frame_length_in;
         mask_key_ff     <= mask_key_in;
         position_ff     <= position_in;
      end
   end

   assign code          = rx_byte[6:0];
   assign position_next = position_ff + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      case (position_ff[1:0])
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      frame_length_in = frame_length_ff;
      mask_key_in     = mask_key_ff;
      position_in     = position_ff;
      result          = '0;
      case (phase_ff)
         PHASE_HDR1: begin
            frame_length_in = '0;
            position_in     = '0;
            if (code == LEN_CODE_EXT64) begin
               phase_in    = PHASE_EXT;
               ext_left_in = EXT64_BYTES;
            end else if (code == LEN_CODE_EXT16) begin
               phase_in    = PHASE_EXT;
               ext_left_in = EXT16_BYTES;
            end else begin
               frame_length_in = {{(LENGTH_BITS-7){1'b0}}, code};
               phase_in        = PHASE_KEY;
               ext_left_in     = KEY_BYTES;
               mask_key_in     = 32'd0;
            end
         end
         PHASE_EXT: begin
            frame_length_in = {frame_length_ff[LENGTH_BITS-9:0], rx_byte};
            ext_left_in     = ext_left_ff - 4'd1;
            if (ext_left_ff == 4'd1) begin
               phase_in    = PHASE_KEY;
               ext_left_in = KEY_BYTES;
               mask_key_in = 32'd0;
            end
         end
         PHASE_KEY: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            ext_left_in = ext_left_ff - 4'd1;
            if (ext_left_ff == 4'd1) begin
               position_in = '0;
               if (frame_length_ff == '0) begin
                  phase_in             = PHASE_HDR0;
                  result.emit          = 1'b1;
                  result.last_in_frame = 1'b1;
                  result.empty_frame   = 1'b1;
               end else begin
                  phase_in = PHASE_BODY;
               end
            end
         end
         PHASE_BODY: begin
            position_in          = position_next;
            result.emit          = 1'b1;
            result.data_byte     = rx_byte ^ key_byte;
            result.last_in_frame = (position_next == frame_length_ff);
            if (position_next == frame_length_ff) begin
               phase_in = PHASE_HDR0;
            end
         end
         default: begin
            phase_in = PHASE_HDR1;
         end
      endcase
   end

endmodule

/* rtl/core/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-stream frame deframer: strips headers, unmasks and flags frame ends.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the result register is empty or
// being drained. Header, length and mask key bytes give no response; each
// payload byte gives one response, and a frame of zero length gives a single
// empty-frame marker after its key. A response is registered in the result
// register in the cycle after its request is taken. A sink that is always
// ready never stalls the input.
// Frame length and payload position are LENGTH_BITS wide; longer lengths keep
// their low bits only.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   wsd_req_if.sink       req_if,
   wsd_rsp_if.source     rsp_if
);

   parse_result_type result;
   logic             take;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_last_ff;
   logic             rsp_empty_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;

   wsd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_if.rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && result.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.emit) begin
         rsp_data_ff  <= result.data_byte;
         rsp_last_ff  <= result.last_in_frame;
         rsp_empty_ff <= result.empty_frame;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.data_byte     = rsp_data_ff;
   assign rsp_if.last_in_frame = rsp_last_ff;
   assign rsp_if.empty_frame   = rsp_empty_ff;

endmodule

/* rtl/core/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last_in_frame,
   input logic       rsp_empty_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |-> rsp_data_byte == 8'd0 && rsp_last_in_frame)
      else $error("empty-frame marker malformed");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with free result register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_stall_if_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while sink ready");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_data_byte     (rsp_if.data_byte),
   .rsp_last_in_frame (rsp_if.last_in_frame),
   .rsp_empty_frame   (rsp_if.empty_frame)
);

/* tb/sv/websocket_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking testbench for the byte-stream frame deframer.
// ----------------------------------------------------------------------------
// Whole frames are sent as byte requests: short, 16-bit and 64-bit lengths,
// empty frames and 64-bit lengths whose upper half is cut away. Each accepted
// byte is run through a local parser that works out the unmasked payload byte
// or empty-frame marker expected from the block. Each response is compared
// with the oldest expectation. Both channels idle at random, the receiver
// once holds off long enough to stall the input, and the sender pauses
// between tests until every response has come.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb
   import wsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LENGTH_BITS = 32;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;

   typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_frame;
      logic       empty_frame;
   } unmasked_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsd_req_if req_chan ();
   wsd_rsp_if rsp_chan ();

   websocket_frame_deframer #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // local parser state
   phase_type              parse_phase;
   logic [3:0]             bytes_left;
   logic [LENGTH_BITS-1:0] frame_length;
   logic [LENGTH_BITS-1:0] payload_position;
   logic [31:0]            mask_key;

   unmasked_byte_type expected_bytes[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int rsp_hold_cycles   = 0;
   int hold_requests     = 0;
   int hold_served       = 0;
   int failures          = 0;
   int bytes_sent        = 0;
   int frames_sent       = 0;
   int payload_checked   = 0;
   int empty_checked     = 0;
   int stall_count       = 0;

   function automatic void queue_expected(input unmasked_byte_type item);
      expected_bytes.insert(expected_bytes.size(), item);
   endfunction

   function automatic unmasked_byte_type take_expected();
      take_expected = expected_bytes[0];
      expected_bytes.delete(0);
   endfunction

   function automatic void begin_mask_key();
      parse_phase = PHASE_KEY;
      bytes_left  = KEY_BYTES;
      mask_key    = '0;
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] rx);
      logic [6:0]        code;
      logic [7:0]        key_byte;
      unmasked_byte_type result;
      case (parse_phase)
         PHASE_HDR1: begin
            code             = rx[6:0];
            frame_length     = '0;
            payload_position = '0;
            if (code == LEN_CODE_EXT64) begin
               parse_phase = PHASE_EXT;
               bytes_left  = EXT64_BYTES;
            end else if (code == LEN_CODE_EXT16) begin
               parse_phase = PHASE_EXT;
               bytes_left  = EXT16_BYTES;
            end else begin
               frame_length = LENGTH_BITS'(code);
               begin_mask_key();
            end
         end
         PHASE_EXT: begin
            frame_length = {frame_length[LENGTH_BITS-9:0], rx};
            bytes_left   = bytes_left - 4'd1;
            if (bytes_left == '0) begin
               begin_mask_key();
            end
         end
         PHASE_KEY: begin
            mask_key   = {mask_key[23:0], rx};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == '0) begin
               payload_position = '0;
               if (frame_length == '0) begin
                  parse_phase = PHASE_HDR0;
                  result      = '{data_byte: 8'h00, last_in_frame: 1'b1, empty_frame: 1'b1};
                  queue_expected(result);
               end else begin
                  parse_phase = PHASE_BODY;
               end
            end
         end
         PHASE_BODY: begin
            key_byte         = mask_key[(3 - payload_position[1:0]) * 8 +: 8];
            payload_position = payload_position + 1'b1;
            result.data_byte     = rx ^ key_byte;
            result.last_in_frame = (payload_position == frame_length);
            result.empty_frame   = 1'b0;
            queue_expected(result);
            if (result.last_in_frame) begin
               parse_phase = PHASE_HDR0;
            end
         end
         default: begin
            parse_phase = PHASE_HDR1;
         end
      endcase
   endfunction

   // predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      unmasked_byte_type want;
      if (reset) begin
         parse_phase      = PHASE_HDR0;
         bytes_left       = '0;
         frame_length     = '0;
         payload_position = '0;
         mask_key         = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            parse_rx_byte(req_chan.rx_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected response: data_byte %0h last %0b empty %0b",
                      rsp_chan.data_byte, rsp_chan.last_in_frame, rsp_chan.empty_frame);
               failures++;
            end else begin
               want = take_expected();
               if (rsp_chan.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h",
                         want.data_byte, rsp_chan.data_byte);
                  failures++;
               end
               if (rsp_chan.last_in_frame !== want.last_in_frame) begin
                  $error("last_in_frame: expected %0b, got %0b",
                         want.last_in_frame, rsp_chan.last_in_frame);
                  failures++;
               end
               if (rsp_chan.empty_frame !== want.empty_frame) begin
                  $error("empty_frame: expected %0b, got %0b",
                         want.empty_frame, rsp_chan.empty_frame);
                  failures++;
               end
               if (want.empty_frame) begin
                  empty_checked++;
               end else begin
                  payload_checked++;
               end
            end
         end
      end
   end

   // receiver: hold off while a stretch is pending, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         rsp_chan.ready  <= 1'b0;
         hold_served     <= hold_requests;
         rsp_hold_cycles <= HOLD_CYCLES;
      end else if (rsp_hold_cycles != 0) begin
         rsp_chan.ready  <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] flags_opcode, input logic mask_bit,
                             input length_form_type form, input logic [63:0] length,
                             input logic [31:0] key);
      logic [LENGTH_BITS-1:0] kept;
      send_byte(flags_opcode);
      case (form)
         FORM_SHORT: begin
            send_byte({mask_bit, length[6:0]});
            kept = LENGTH_BITS'(length[6:0]);
         end
         FORM_EXT16: begin
            send_byte({mask_bit, LEN_CODE_EXT16});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
            kept = LENGTH_BITS'(length[15:0]);
         end
         default: begin
            send_byte({mask_bit, LEN_CODE_EXT64});
            for (int i = 7; i >= 0; i--) begin
               send_byte(length[8*i +: 8]);
            end
            kept = length[LENGTH_BITS-1:0];
         end
      endcase
      for (int i = 3; i >= 0; i--) begin
         send_byte(key[8*i +: 8]);
      end
      for (longint n = 0; n < kept; n++) begin
         send_byte(8'($urandom_range(0, 255)));
      end
      frames_sent++;
   endtask

   // drop valid and hold until every expected response has come
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_empty_frame();
      send_frame(8'h00, 1'b1, FORM_SHORT, 64'd0, 32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_length_over_range();
      send_frame(8'hFF, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_0000_0001, 32'hFF00_AA55);
      wait_drained();
   endtask

   task automatic test_ext16_length();
      send_frame(8'h81, 1'b0, FORM_EXT16, 64'd2, 32'h1234_5678);
      wait_drained();
   endtask

   task automatic test_input_stall();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_requests++;
      send_frame(8'h82, 1'b1, FORM_EXT16, 64'd300, $urandom());
      wait_drained();
   endtask

   task automatic test_random_frames(input int send_pct, input int recv_pct,
                                     input int count);
      int          stop_at;
      int          pick;
      logic [7:0]  flags_opcode;
      logic        mask_bit;
      logic [31:0] key;
      stop_at           = bytes_sent + count;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      while (bytes_sent < stop_at) begin
         pick         = $urandom_range(0, 99);
         flags_opcode = 8'($urandom_range(0, 255));
         mask_bit     = 1'($urandom_range(0, 1));
         key          = $urandom();
         if (pick < 55) begin
            send_frame(flags_opcode, mask_bit, FORM_SHORT,
                       64'($urandom_range(0, 12)), key);
         end else if (pick < 58) begin
            send_frame(flags_opcode, mask_bit, FORM_SHORT, 64'd125, key);
         end else if (pick < 80) begin
            send_frame(flags_opcode, mask_bit, FORM_EXT16,
                       64'($urandom_range(0, 24)), key);
         end else begin
            send_frame(flags_opcode, mask_bit, FORM_EXT64,
                       {$urandom(), 32'($urandom_range(0, 24))}, key);
         end
      end
      wait_drained();
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 36;
      receiver_idle_pct = 50;
      test_empty_frame();
      test_length_over_range();
      test_ext16_length();
      test_input_stall();
      test_random_frames(36, 50, 365);
      test_random_frames(50, 36, 365);
      test_random_frames(0, 0, 365);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected responses never arrived", expected_bytes.size());
      end
      $display("sent %0d bytes in %0d frames (short, 16-bit, 64-bit and cut lengths)",
               bytes_sent, frames_sent);
      $display("checked %0d payload bytes and %0d empty-frame markers",
               payload_checked, empty_checked);
      if (failures == 0 && expected_bytes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
